FILE: rtl/core/blca_pkg.sv
// Shared types, sizes and helpers for the binary-lifting ancestor block.
package blca_pkg;

    localparam int NODES  = 4096;
    localparam int LEVELS = 12;

    localparam int NODE_W    = 12;
    localparam int DEP_W     = 12;
    localparam int ENT_W     = NODE_W + 1;
    localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int ANC_DEPTH = NODES * LEVELS;
    localparam int ANC_AW    = $clog2(ANC_DEPTH);

    localparam logic [DEP_W-1:0] DEPTH_MAX = '1;
    localparam logic [LVL_W-1:0] LVL_LAST  = LVL_W'(LEVELS - 1);

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic              command;
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] other_node;
        logic              is_root;
    } in_t;

    typedef struct packed {
        logic [NODE_W-1:0] ancestor_node;
        logic [DEP_W-1:0]  path_length;
    } out_t;

    typedef struct packed {
        logic              we;
        logic [ANC_AW-1:0] addr;
        logic [ENT_W-1:0]  wdata;
    } anc_req_t;

    typedef struct packed {
        logic              we;
        logic [NODE_W-1:0] addr;
        logic [DEP_W-1:0]  wdata;
    } dep_req_t;

    // Flat address of jump entry lv of node nd.
    function automatic logic [ANC_AW-1:0] anc_addr(input logic [NODE_W-1:0] nd,
                                                   input logic [LVL_W-1:0] lv);
        return ANC_AW'(nd) * ANC_AW'(LEVELS) + ANC_AW'(lv);
    endfunction

    // Node number held by a valid jump entry.
    function automatic logic [NODE_W-1:0] ent_node(input logic [ENT_W-1:0] ent);
        logic [ENT_W-1:0] dec;
        dec = ent - ENT_W'(1);
        return dec[NODE_W-1:0];
    endfunction

endpackage

FILE: rtl/core/blca_mem.sv
// Ancestor table and depth store, each a single-port synchronous memory.
module blca_mem (
    input  logic                            aclk,
    input  blca_pkg::anc_req_t              anc_req,
    output logic [blca_pkg::ENT_W-1:0]      anc_rdata,
    input  blca_pkg::dep_req_t              dep_req,
    output logic [blca_pkg::DEP_W-1:0]      dep_rdata
);

    logic [blca_pkg::ENT_W-1:0] anc_mem [0:blca_pkg::ANC_DEPTH-1];
    logic [blca_pkg::DEP_W-1:0] dep_mem [0:blca_pkg::NODES-1];

    always_ff @(posedge aclk) begin
        if (anc_req.we) begin
            anc_mem[anc_req.addr] <= anc_req.wdata;
        end
        anc_rdata <= anc_mem[anc_req.addr];
    end

    always_ff @(posedge aclk) begin
        if (dep_req.we) begin
            dep_mem[dep_req.addr] <= dep_req.wdata;
        end
        dep_rdata <= dep_mem[dep_req.addr];
    end

endmodule

FILE: rtl/core/binary_lifting_lca.sv
// Top level of the binary-lifting lowest-common-ancestor engine.
//
// The input channel (s_valid, s_ready, s_data) takes one request at a time.
// A load request stores a node, either as a root or under a parent loaded
// earlier; it produces no result. A query request names two nodes and
// produces one result (m_valid, m_ready, m_data) with their lowest common
// ancestor and the number of edges between them, or none when the nodes
// lie in different trees.
// A load writes the jump entries one level at a time. In a query, both
// lifting passes walk the ancestor table one level at a time, and each
// level costs two reads through the single port of that table or of the
// depth store.
// s_ready is high only while the engine is idle. The result sits in an
// output register, so a new request is taken while a result still waits;
// if that register is still full when the next query finishes, the
// engine holds in its last state until the receiver takes the old result.
// Reset clears the control state and the output valid only. The memories
// are not cleared, so every node must be loaded before a query reads it.
module binary_lifting_lca (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  blca_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output blca_pkg::out_t  m_data
);

    typedef enum logic [19:0] {
        S_IDLE = 20'h00001,
        S_ROOT = 20'h00002,
        S_LPAR = 20'h00004,
        S_LDEP = 20'h00008,
        S_LREQ = 20'h00010,
        S_LWR  = 20'h00020,
        S_QDA  = 20'h00040,
        S_QDB  = 20'h00080,
        S_QSW  = 20'h00100,
        S_P1A  = 20'h00200,
        S_P1B  = 20'h00400,
        S_P1C  = 20'h00800,
        S_EQ   = 20'h01000,
        S_P2A  = 20'h02000,
        S_P2B  = 20'h04000,
        S_P2C  = 20'h08000,
        S_FIN  = 20'h10000,
        S_FIN2 = 20'h20000,
        S_DAN  = 20'h40000,
        S_OUT  = 20'h80000
    } state_t;

    state_t state_reg, state_next;

    // During a load, u holds the node and v its parent. During a query,
    // u is the shallower node and v the one being lifted.
    logic [blca_pkg::NODE_W-1:0] u_reg, u_next;
    logic [blca_pkg::NODE_W-1:0] v_reg, v_next;
    logic [blca_pkg::NODE_W-1:0] anc_node_reg, anc_node_next;
    logic [blca_pkg::LVL_W-1:0]  level_reg, level_next;
    logic [blca_pkg::ENT_W-1:0]  prev_reg, prev_next;
    logic [blca_pkg::ENT_W-1:0]  e_reg, e_next;
    logic [blca_pkg::DEP_W-1:0]  da_reg, da_next;
    logic [blca_pkg::DEP_W-1:0]  db_reg, db_next;
    logic [blca_pkg::DEP_W-1:0]  du_reg, du_next;
    logic                        m_valid_reg, m_valid_next;
    blca_pkg::out_t              m_data_reg, m_data_next;

    blca_pkg::anc_req_t          anc_req;
    blca_pkg::dep_req_t          dep_req;
    logic [blca_pkg::ENT_W-1:0]  anc_rdata;
    logic [blca_pkg::DEP_W-1:0]  dep_rdata;

    logic                        out_free;
    logic                        load_out;
    logic [blca_pkg::DEP_W+1:0]  len_raw;
    logic [blca_pkg::DEP_W-1:0]  len_sat;
    logic [blca_pkg::DEP_W-1:0]  child_depth;

    blca_mem u_mem (
        .aclk      (aclk),
        .anc_req   (anc_req),
        .anc_rdata (anc_rdata),
        .dep_req   (dep_req),
        .dep_rdata (dep_rdata)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;

    // Path length in two's complement, wide enough for every depth triple.
    // The depth of the ancestor arrives on the depth read port in S_OUT.
    assign len_raw = {2'b00, da_reg} + {2'b00, db_reg} - {1'b0, dep_rdata, 1'b0};

    always_comb begin
        if (len_raw[blca_pkg::DEP_W+1]) begin
            len_sat = '0;
        end else if (len_raw[blca_pkg::DEP_W]) begin
            len_sat = blca_pkg::DEPTH_MAX;
        end else begin
            len_sat = len_raw[blca_pkg::DEP_W-1:0];
        end
    end

    assign child_depth = (dep_rdata == blca_pkg::DEPTH_MAX) ? blca_pkg::DEPTH_MAX
                                                            : dep_rdata + 1'b1;

    always_comb begin
        state_next    = state_reg;
        u_next        = u_reg;
        v_next        = v_reg;
        anc_node_next = anc_node_reg;
        level_next    = level_reg;
        prev_next     = prev_reg;
        e_next        = e_reg;
        da_next       = da_reg;
        db_next       = db_reg;
        du_next       = du_reg;
        load_out      = 1'b0;
        anc_req       = '0;
        dep_req       = '0;

        unique case (state_reg)
            S_IDLE: begin
                level_next = '0;
                if (s_valid) begin
                    u_next = s_data.node;
                    v_next = s_data.other_node;
                    if (s_data.command == blca_pkg::CMD_QUERY) begin
                        state_next = S_QDA;
                    end else if (s_data.is_root) begin
                        state_next = S_ROOT;
                    end else begin
                        state_next = S_LPAR;
                    end
                end
            end

            // A root gets depth zero and every jump entry invalid.
            S_ROOT: begin
                anc_req.we   = 1'b1;
                anc_req.addr = blca_pkg::anc_addr(u_reg, level_reg);
                if (level_reg == '0) begin
                    dep_req.we   = 1'b1;
                    dep_req.addr = u_reg;
                end
                if (level_reg == blca_pkg::LVL_LAST) begin
                    state_next = S_IDLE;
                end else begin
                    level_next = level_reg + 1'b1;
                end
            end

            S_LPAR: begin
                dep_req.addr = v_reg;
                state_next   = S_LDEP;
            end

            // The parent's depth is read before the child's is written, so a
            // node given as its own parent still sees the old value.
            S_LDEP: begin
                dep_req.we    = 1'b1;
                dep_req.addr  = u_reg;
                dep_req.wdata = child_depth;
                anc_req.we    = 1'b1;
                anc_req.addr  = blca_pkg::anc_addr(u_reg, '0);
                anc_req.wdata = {1'b0, v_reg} + 1'b1;
                prev_next     = {1'b0, v_reg} + 1'b1;
                if (level_reg == blca_pkg::LVL_LAST) begin
                    state_next = S_IDLE;
                end else begin
                    level_next = level_reg + 1'b1;
                    state_next = S_LREQ;
                end
            end

            // Entry i is entry i-1 of the ancestor held in entry i-1.
            S_LREQ: begin
                if (prev_reg != '0) begin
                    anc_req.addr = blca_pkg::anc_addr(blca_pkg::ent_node(prev_reg),
                                                      level_reg - 1'b1);
                    state_next   = S_LWR;
                end else begin
                    anc_req.we   = 1'b1;
                    anc_req.addr = blca_pkg::anc_addr(u_reg, level_reg);
                    if (level_reg == blca_pkg::LVL_LAST) begin
                        state_next = S_IDLE;
                    end else begin
                        level_next = level_reg + 1'b1;
                    end
                end
            end

            S_LWR: begin
                anc_req.we    = 1'b1;
                anc_req.addr  = blca_pkg::anc_addr(u_reg, level_reg);
                anc_req.wdata = anc_rdata;
                prev_next     = anc_rdata;
                if (level_reg == blca_pkg::LVL_LAST) begin
                    state_next = S_IDLE;
                end else begin
                    level_next = level_reg + 1'b1;
                    state_next = S_LREQ;
                end
            end

            S_QDA: begin
                dep_req.addr = u_reg;
                state_next   = S_QDB;
            end

            S_QDB: begin
                dep_req.addr = v_reg;
                da_next      = dep_rdata;
                state_next   = S_QSW;
            end

            // Put the shallower node in u; ties keep the request order.
            S_QSW: begin
                db_next    = dep_rdata;
                level_next = blca_pkg::LVL_LAST;
                if (da_reg > dep_rdata) begin
                    u_next  = v_reg;
                    v_next  = u_reg;
                    du_next = dep_rdata;
                end else begin
                    du_next = da_reg;
                end
                state_next = S_P1A;
            end

            // First pass: lift v while the jump target stays at or below
            // the depth of u.
            S_P1A: begin
                anc_req.addr = blca_pkg::anc_addr(v_reg, level_reg);
                state_next   = S_P1B;
            end

            S_P1B: begin
                if (anc_rdata != '0) begin
                    dep_req.addr = blca_pkg::ent_node(anc_rdata);
                    e_next       = anc_rdata;
                    state_next   = S_P1C;
                end else if (level_reg == '0) begin
                    state_next = S_EQ;
                end else begin
                    level_next = level_reg - 1'b1;
                    state_next = S_P1A;
                end
            end

            S_P1C: begin
                if (dep_rdata >= du_reg) begin
                    v_next = blca_pkg::ent_node(e_reg);
                end
                if (level_reg == '0) begin
                    state_next = S_EQ;
                end else begin
                    level_next = level_reg - 1'b1;
                    state_next = S_P1A;
                end
            end

            S_EQ: begin
                if (u_reg == v_reg) begin
                    anc_node_next = u_reg;
                    state_next    = S_DAN;
                end else begin
                    level_next = blca_pkg::LVL_LAST;
                    state_next = S_P2A;
                end
            end

            // Second pass: lift both while their jump targets differ and
            // both are valid.
            S_P2A: begin
                anc_req.addr = blca_pkg::anc_addr(u_reg, level_reg);
                state_next   = S_P2B;
            end

            S_P2B: begin
                e_next       = anc_rdata;
                anc_req.addr = blca_pkg::anc_addr(v_reg, level_reg);
                state_next   = S_P2C;
            end

            S_P2C: begin
                if (e_reg != anc_rdata && e_reg != '0 && anc_rdata != '0) begin
                    u_next = blca_pkg::ent_node(e_reg);
                    v_next = blca_pkg::ent_node(anc_rdata);
                end
                if (level_reg == '0) begin
                    state_next = S_FIN;
                end else begin
                    level_next = level_reg - 1'b1;
                    state_next = S_P2A;
                end
            end

            S_FIN: begin
                anc_req.addr = blca_pkg::anc_addr(u_reg, '0);
                state_next   = S_FIN2;
            end

            // No parent above the meeting point: the nodes are in
            // different trees and the query yields nothing.
            S_FIN2: begin
                if (anc_rdata == '0) begin
                    state_next = S_IDLE;
                end else begin
                    anc_node_next = blca_pkg::ent_node(anc_rdata);
                    state_next    = S_DAN;
                end
            end

            S_DAN: begin
                dep_req.addr = anc_node_reg;
                state_next   = S_OUT;
            end

            // Keep reading the ancestor's depth so it stays on the port
            // while the output register is still full.
            S_OUT: begin
                dep_req.addr = anc_node_reg;
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = (m_valid_reg && !m_ready) || load_out;
        m_data_next  = m_data_reg;
        if (load_out) begin
            m_data_next.ancestor_node = anc_node_reg;
            m_data_next.path_length   = len_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        u_reg        <= u_next;
        v_reg        <= v_next;
        anc_node_reg <= anc_node_next;
        level_reg    <= level_next;
        prev_reg     <= prev_next;
        e_reg        <= e_next;
        da_reg       <= da_next;
        db_reg       <= db_next;
        du_reg       <= du_next;
        m_data_reg   <= m_data_next;
    end

`ifndef SYNTHESIS
    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result appeared outside the output state");

    a_query_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.command == blca_pkg::CMD_QUERY)
        |=> (state_reg == S_QDA))
        else $error("accepted query did not start the depth reads");

    a_no_write_in_query: assert property (@(posedge aclk) disable iff (!aresetn)
        anc_req.we |-> (state_reg == S_ROOT || state_reg == S_LDEP
                        || state_reg == S_LREQ || state_reg == S_LWR))
        else $error("ancestor table written outside a load");

    a_jump_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_P1C) |-> (e_reg != '0))
        else $error("first pass followed an invalid jump entry");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(m_data_reg)))
        else $error("waiting result was overwritten or dropped");
`endif

endmodule

FILE: test/tb_binary_lifting_lca.sv
`timescale 1ns / 100ps
// Self-checking testbench for binary_lifting_lca: directed tree cases, then random requests.
module tb_binary_lifting_lca;

    // Stimulus sizes: twenty directed requests and the random part, about 1550 in all.
    localparam int RANDOM_REQUESTS = 1530;
    localparam int DIRECTED_ROWS   = 19;

    // The slowest correct run is a query on every request, with the longest sender
    // gap and the longest receiver stall each time. The limit stays well above it.
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 200;
    localparam int REPORT_MAX  = 10;

    // How a row of the directed table is checked: against the predictor, against
    // a result typed into the row, or as a query that must give no result.
    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_TYPED,
        CHK_SILENT
    } check_t;

    typedef struct {
        blca_pkg::in_t  req;
        int             reps;
        check_t         chk;
        blca_pkg::out_t res;
    } step_t;

    logic           aclk    = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    blca_pkg::in_t  s_data  = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    blca_pkg::out_t m_data;

    // The testbench's own copy of the tree: jump entries (zero means no ancestor,
    // k + 1 means node k) and depths. Entries are only read for loaded nodes.
    logic [blca_pkg::ENT_W-1:0] jump_tbl  [blca_pkg::NODES][blca_pkg::LEVELS];
    logic [blca_pkg::DEP_W-1:0] depth_tbl [blca_pkg::NODES];

    // Bookkeeping for the stimulus, so that no request ever reads an unloaded node.
    bit   node_loaded [blca_pkg::NODES];
    int   loaded_nodes [$];

    // Expected ancestor results, oldest first.
    blca_pkg::out_t pending_lca [$];

    int   fail_count  = 0;
    int   cycle_count = 0;
    int   rx_hold     = 0;
    bit   tx_calm     = 1'b0;

    binary_lifting_lca dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Gap length for either side: mostly none, often a few cycles, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic flag_error(input string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Applies one request to the testbench's tree. A load updates the depth and
    // jump entries and returns 0. A query lifts the deeper node to the level of
    // the other, then lifts both while their entries differ and both are valid,
    // and returns 1 with the ancestor and the clamped path length, or 0 when the
    // two nodes end up with no common ancestor.
    function automatic bit tree_apply(input blca_pkg::in_t req, output blca_pkg::out_t res);
        logic [blca_pkg::NODE_W-1:0] a, b, u, v, t, anc;
        logic [blca_pkg::ENT_W-1:0]  e, eu, ev;
        int                          len;
        a   = req.node;
        b   = req.other_node;
        res = '0;
        if (req.command == blca_pkg::CMD_LOAD) begin
            if (req.is_root) begin
                depth_tbl[a] = '0;
                for (int i = 0; i < blca_pkg::LEVELS; i++)
                    jump_tbl[a][i] = '0;
            end else begin
                // The parent's depth is read before the node's own is written, so
                // a node loaded under itself simply goes one level deeper.
                depth_tbl[a] = (depth_tbl[b] == blca_pkg::DEPTH_MAX)
                             ? blca_pkg::DEPTH_MAX : depth_tbl[b] + 1'b1;
                jump_tbl[a][0] = {1'b0, b} + 1'b1;
                for (int i = 1; i < blca_pkg::LEVELS; i++) begin
                    e = jump_tbl[a][i-1];
                    jump_tbl[a][i] = (e != '0) ? jump_tbl[blca_pkg::ent_node(e)][i-1] : '0;
                end
            end
            return 1'b0;
        end

        u = a;
        v = b;
        if (depth_tbl[u] > depth_tbl[v]) begin
            t = u;
            u = v;
            v = t;
        end
        for (int i = blca_pkg::LEVELS - 1; i >= 0; i--) begin
            e = jump_tbl[v][i];
            if (e != '0 && depth_tbl[blca_pkg::ent_node(e)] >= depth_tbl[u])
                v = blca_pkg::ent_node(e);
        end
        if (u == v) begin
            anc = u;
        end else begin
            for (int i = blca_pkg::LEVELS - 1; i >= 0; i--) begin
                eu = jump_tbl[u][i];
                ev = jump_tbl[v][i];
                if (eu != ev && eu != '0 && ev != '0) begin
                    u = blca_pkg::ent_node(eu);
                    v = blca_pkg::ent_node(ev);
                end
            end
            if (jump_tbl[u][0] == '0)
                return 1'b0;
            anc = blca_pkg::ent_node(jump_tbl[u][0]);
        end
        len = int'(depth_tbl[a]) + int'(depth_tbl[b]) - 2 * int'(depth_tbl[anc]);
        if (len < 0)
            len = 0;
        if (len > int'(blca_pkg::DEPTH_MAX))
            len = int'(blca_pkg::DEPTH_MAX);
        res.ancestor_node = anc;
        res.path_length   = len[blca_pkg::DEP_W-1:0];
        return 1'b1;
    endfunction

    function automatic blca_pkg::in_t load_req(input int n, input int parent);
        blca_pkg::in_t r;
        r.command    = blca_pkg::CMD_LOAD;
        r.node       = n[blca_pkg::NODE_W-1:0];
        r.other_node = parent[blca_pkg::NODE_W-1:0];
        r.is_root    = 1'b0;
        return r;
    endfunction

    // The parent field of a root load is ignored by the block, so it carries junk.
    function automatic blca_pkg::in_t root_req(input int n, input int junk);
        blca_pkg::in_t r;
        r.command    = blca_pkg::CMD_LOAD;
        r.node       = n[blca_pkg::NODE_W-1:0];
        r.other_node = junk[blca_pkg::NODE_W-1:0];
        r.is_root    = 1'b1;
        return r;
    endfunction

    function automatic blca_pkg::in_t query_req(input int a, input int b, input bit flag);
        blca_pkg::in_t r;
        r.command    = blca_pkg::CMD_QUERY;
        r.node       = a[blca_pkg::NODE_W-1:0];
        r.other_node = b[blca_pkg::NODE_W-1:0];
        r.is_root    = flag;
        return r;
    endfunction

    // Recent nodes are favored, so random trees grow deep instead of bushy.
    function automatic int pick_loaded();
        int cnt;
        cnt = loaded_nodes.size();
        if (cnt > 16 && $urandom_range(0, 9) < 6)
            return loaded_nodes[cnt - 1 - $urandom_range(0, 15)];
        return loaded_nodes[$urandom_range(0, cnt - 1)];
    endfunction

    function automatic int pick_fresh();
        int n;
        do
            n = $urandom_range(0, blca_pkg::NODES - 1);
        while (node_loaded[n]);
        return n;
    endfunction

    // Random requests are mostly well formed: new children under loaded parents,
    // a few new roots, and queries between loaded nodes. The rest reloads a node
    // under another, under itself or as a root, which can leave the tree
    // inconsistent or cyclic on purpose.
    function automatic blca_pkg::in_t random_request();
        int kind, a;
        kind = $urandom_range(0, 99);
        if (kind < 40)
            return load_req(pick_fresh(), pick_loaded());
        if (kind < 44)
            return root_req(pick_fresh(), $urandom_range(0, blca_pkg::NODES - 1));
        if (kind < 86)
            return query_req(pick_loaded(), pick_loaded(), 1'($urandom_range(0, 1)));
        a = pick_loaded();
        if (kind < 90)
            return query_req(a, a, 1'($urandom_range(0, 1)));
        case ($urandom_range(0, 2))
            0: begin
                return load_req(a, pick_loaded());
            end
            1: begin
                return load_req(a, a);
            end
            default: begin
                return root_req(a, $urandom_range(0, blca_pkg::NODES - 1));
            end
        endcase
    endfunction

    // Offers one request and holds it until the block takes it. The expectation is
    // worked out at the accepting edge, so expectations stay in request order.
    // Valid is only lowered when a gap follows, so back-to-back requests keep it high.
    task automatic send_request(input blca_pkg::in_t req, input check_t chk,
                                input blca_pkg::out_t typed);
        blca_pkg::out_t got;
        bit             has;
        int             gap;
        s_valid <= 1'b1;
        s_data  <= req;
        do
            @(posedge aclk);
        while (!s_ready);
        if (req.command == blca_pkg::CMD_LOAD && !node_loaded[req.node]) begin
            node_loaded[req.node] = 1'b1;
            loaded_nodes = {loaded_nodes, int'(req.node)};
        end
        has = tree_apply(req, got);
        if (chk == CHK_TYPED)
            pending_lca = {pending_lca, typed};
        else if (chk == CHK_PREDICT && has)
            pending_lca = {pending_lca, got};
        gap = tx_calm ? 0 : idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // The sender stops until every outstanding result has been taken. It always
    // waits for a clock edge before checking, so valid is never lowered and raised in one step.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do
            @(posedge aclk);
        while (pending_lca.size() != 0);
    endtask

    // Receiver pacing: random stalls of mixed length, with a stretch of steady
    // ready at the start of each period of the cycle counter.
    always @(posedge aclk) begin : rx_pace
        int g;
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_ready <= 1'b0;
        end else if (cycle_count % 2000 < 400) begin
            m_ready <= 1'b1;
        end else begin
            g = idle_len();
            if (g == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                rx_hold <= g - 1;
            end
        end
    end

    // Every result taken is compared field by field with the oldest expectation.
    always @(posedge aclk) begin : result_check
        blca_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_lca.size() == 0) begin
                flag_error($sformatf("unexpected result: ancestor %0d, length %0d",
                                     m_data.ancestor_node, m_data.path_length));
            end else begin
                want = pending_lca.pop_front();
                if (m_data.ancestor_node !== want.ancestor_node)
                    flag_error($sformatf("ancestor_node: expected %0d, got %0d",
                                         want.ancestor_node, m_data.ancestor_node));
                if (m_data.path_length !== want.path_length)
                    flag_error($sformatf("path_length: expected %0d, got %0d",
                                         want.path_length, m_data.path_length));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("binary_lifting_lca verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        step_t directed_plan [DIRECTED_ROWS];
        step_t row;

        // Directed table. Nodes 0 and 4095 sit at the extremes of the node field.
        // Results are typed in only where they are obvious; the rest are predicted.
        directed_plan = '{
            // A lone root queried against itself is its own ancestor, at distance 0.
            '{root_req(0, 4095),           1, CHK_PREDICT, '0},
            '{query_req(0, 0, 1'b0),       1, CHK_TYPED,   '{12'd0, 12'd0}},
            // A small tree: 0 -> 4095 -> {1, 2}, 1 -> 2048.
            '{load_req(4095, 0),           1, CHK_PREDICT, '0},
            '{load_req(1, 4095),           1, CHK_PREDICT, '0},
            '{load_req(2, 4095),           1, CHK_PREDICT, '0},
            '{load_req(2048, 1),           1, CHK_PREDICT, '0},
            // The deeper node first, then second, then an ancestor against a leaf.
            '{query_req(2048, 2, 1'b0),    1, CHK_PREDICT, '0},
            '{query_req(2, 2048, 1'b1),    1, CHK_PREDICT, '0},
            '{query_req(0, 2048, 1'b0),    1, CHK_PREDICT, '0},
            // The root flag is ignored on a query.
            '{query_req(4095, 4095, 1'b1), 1, CHK_TYPED,   '{12'd4095, 12'd0}},
            // A second tree: its nodes share no ancestor with the first, so no result.
            '{root_req(4094, 0),           1, CHK_PREDICT, '0},
            '{query_req(2048, 4094, 1'b0), 1, CHK_SILENT,  '0},
            // A node reloaded under itself keeps the entries as they come out.
            '{load_req(2, 2),              1, CHK_PREDICT, '0},
            '{query_req(2, 1, 1'b0),       1, CHK_PREDICT, '0},
            // Raising a parent's depth after its children were loaded makes the
            // path length come out negative, which clamps to zero.
            '{root_req(100, 2730),         1, CHK_PREDICT, '0},
            '{load_req(101, 100),          1, CHK_PREDICT, '0},
            '{load_req(102, 100),          1, CHK_PREDICT, '0},
            '{load_req(100, 100),          2, CHK_PREDICT, '0},
            '{query_req(101, 102, 1'b0),   1, CHK_TYPED,   '{12'd100, 12'd0}}
        };

        // Synchronous reset, held low from the start and released once.
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_plan[k]) begin
            row = directed_plan[k];
            repeat (row.reps) send_request(row.req, row.chk, row.res);
        end
        wait_for_results();

        // Random part. Every so often the sender runs without gaps for a stretch,
        // and now and then it waits for the block to drain completely.
        for (int k = 0; k < RANDOM_REQUESTS; k++) begin
            if (k % 150 == 0)
                tx_calm = ($urandom_range(0, 3) == 0);
            if (k % 250 == 249)
                wait_for_results();
            send_request(random_request(), CHK_PREDICT, '0);
        end

        // Let the last query finish; anything arriving now is unexpected.
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_lca.size() != 0)
            flag_error($sformatf("%0d expected results never arrived", pending_lca.size()));

        if (fail_count == 0) begin
            $display("binary_lifting_lca verification clean");
        end else begin
            $display("binary_lifting_lca verification failed");
        end
        $finish;
    end

endmodule
